// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the zpd RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ZPD_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("zpd: assertion failed");

// Expression must never be true out of reset.
`define ZPD_NEVER(name, expr) \
	`ZPD_ASSERT(name, !(expr))

`endif

// ----- rtl/core/zpd_pkg.sv -----
// Shared types and constants for the z-score peak detector.
// No dependencies; imported by zpd_mac and zscore_peak_detector_core.
package zpd_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int COUNT_BITS_DEF  = 16;

	// shared multiplier consumes one digit of its B operand per cycle
	localparam int DIG_W = 8;

	localparam int CALIB_BITS   = 8;
	localparam int THR_BITS     = 8;
	localparam int HOLD_BITS    = 16;
	localparam int TICK_BITS    = 16;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int LEFT_SHIFT   = 4;   // factor 16 on the deviation side
	localparam int MIN_CALIB    = 2;

	localparam logic [CALIB_BITS-1:0] CALIB_RST   = 8'd10;
	localparam logic [THR_BITS-1:0]   THR_RST     = 8'd12;
	localparam logic [HOLD_BITS-1:0]  HOLD_RST    = 16'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_CALIB   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF = 2'd2;

	localparam logic [1:0] STATUS_CALIB = 2'd0;
	localparam logic [1:0] STATUS_BG    = 2'd1;
	localparam logic [1:0] STATUS_PEAK  = 2'd2;
	localparam logic [1:0] STATUS_TICK  = 2'd3;

	typedef struct packed {
		logic load;   // take new A and B operands
		logic clr;    // clear accumulator (only with load)
		logic step;   // one digit: acc +/- A*digit, shift operands
		logic sub;    // subtract this digit's partial product
	} zpd_mac_ctl_t;

endpackage

// ----- rtl/core/zscore_peak_detector_core.sv -----
// Top level of the z-score peak detector: sequencer, statistics and ports.
// Depends on zpd_pkg, zpd_mac and assert_macros.svh.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------
//  in      | in_valid / in_ready   | command, sample
//  out     | out_valid / out_ready | status, peak_level
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A tick skips the multiplier. A calibration sample runs one x*x operation; a tested
// sample runs the full sequence, longer when it joins the background or sets a new largest peak.
// Time per operation is set by the shared multiplier, 8 bits of B operand per cycle,
// plus the sequencing state ST_NEXT after each operation.
// The next word is taken while a result waits in the output register; the
// sequencer stalls only in ST_OUT until the output register is free.
// Reset clears all statistics and restores the configuration defaults.
`include "assert_macros.svh"

module zscore_peak_detector_core import zpd_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   command,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             status,
	output logic [SAMPLE_BITS-1:0] peak_level,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int SB      = SAMPLE_BITS;
	localparam int CB      = COUNT_BITS;
	localparam int SUM_W   = SB + CB;
	localparam int SQ_W    = 2 * SB + CB;
	localparam int VAR_W   = 2 * SB + 2 * CB;
	localparam int LEFT_W  = 2 * SUM_W + CB + LEFT_SHIFT;
	localparam int ACC_W   = VAR_W + CB + 2 * THR_BITS;
	localparam int B_W     = SUM_W;
	localparam int DIV_SH  = SB + 4;
	localparam int DIV_RW  = DIV_SH - 1;
	localparam int DIV_RECIP = ((1 << DIV_SH) + 2) / 3;
	localparam int DIG_CNT  = (CB + DIG_W - 1) / DIG_W;
	localparam int DIG_SUM  = (SUM_W + DIG_W - 1) / DIG_W;
	localparam int DIG_LEFT = (CB + LEFT_SHIFT + DIG_W - 1) / DIG_W;
	localparam int DIG_SQ   = (SB + DIG_W - 1) / DIG_W;
	localparam int DIG_THR  = (THR_BITS + DIG_W - 1) / DIG_W;
	localparam int DIG_DIV  = (DIV_RW + DIG_W - 1) / DIG_W;
	localparam int CNT_W    = $clog2(DIG_SUM);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_NEXT = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	// operations on the shared unit
	typedef enum logic [3:0] {
		OP_SQ,    // x*x for a calibration or background update
		OP_NX,    // n*x
		OP_D2,    // d*d, d = |n*x - S|
		OP_LEFT,  // d^2 * 16(n-1)
		OP_NQ,    // n*Q
		OP_SS,    // minus S*S
		OP_RN,    // var * n
		OP_RV1,   // * v
		OP_RV2,   // * v
		OP_DIV    // (2x+prev) * recip(3)
	} op_t;

	state_t state_q;
	op_t    op_q;
	logic [CNT_W-1:0] cnt_q;

	logic [CALIB_BITS-1:0] calib_q;
	logic [THR_BITS-1:0]   thr_q;
	logic [HOLD_BITS-1:0]  hold_q;

	logic [CB-1:0]        count_q;
	logic [SUM_W-1:0]     sum_q;
	logic [SQ_W-1:0]      sq_q;
	logic [SB-1:0]        prev_q;
	logic [SB-1:0]        largest_q;
	logic [SB-1:0]        smoothed_q;
	logic [TICK_BITS-1:0] ticks_q;

	logic             cmd_q;
	logic [SB-1:0]    x_q;
	logic [LEFT_W-1:0] keep_q;
	logic [1:0]       pend_q;

	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [SB-1:0]    level_q;

	logic st_idle, st_run, st_next, st_out;
	logic in_acc, out_free;
	logic [CALIB_BITS-1:0] calib_eff;
	logic calibrating;
	logic [SB-1:0]    x_cur;
	logic [SUM_W-1:0] nx_w, d_w;
	logic [VAR_W-1:0] var_w;
	logic [CB-1:0]    n_m1;
	logic [ACC_W-1:0] acc;
	logic outlier;
	logic report;
	logic load_go;
	op_t  ld_op;
	logic [ACC_W-1:0] a_in;
	logic [B_W-1:0]   b_in;
	logic [CNT_W-1:0] ld_cnt;
	zpd_mac_ctl_t     mac_ctl;

	assign st_idle = (state_q == ST_IDLE);
	assign st_run  = (state_q == ST_RUN);
	assign st_next = (state_q == ST_NEXT);
	assign st_out  = (state_q == ST_OUT);

	assign in_ready   = st_idle;
	assign in_acc     = in_valid && st_idle;
	assign out_free   = !out_valid_q || out_ready;
	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign peak_level = level_q;

	assign calib_eff   = (calib_q < CALIB_BITS'(MIN_CALIB)) ? CALIB_BITS'(MIN_CALIB) : calib_q;
	assign calibrating = count_q < CB'(calib_eff);
	assign x_cur       = st_idle ? sample : x_q;

	assign nx_w    = acc[SUM_W-1:0];
	assign d_w     = (nx_w >= sum_q) ? nx_w - sum_q : sum_q - nx_w;
	// acc is wider than the variance, so its top bit is the sign of n*Q - S^2
	assign var_w   = acc[ACC_W-1] ? '0 : acc[VAR_W-1:0];
	assign n_m1    = count_q - CB'(1);
	assign outlier = ACC_W'(keep_q) > acc;
	assign report  = ticks_q > hold_q;

	// pick the next operation
	always_comb begin
		load_go = 1'b0;
		ld_op   = OP_NX;
		if (in_acc && !command) begin
			load_go = 1'b1;
			ld_op   = calibrating ? OP_SQ : OP_NX;
		end else if (st_next) begin
			unique case (op_q)
				OP_NX:   begin load_go = 1'b1; ld_op = OP_D2;   end
				OP_D2:   begin load_go = 1'b1; ld_op = OP_LEFT; end
				OP_LEFT: begin load_go = 1'b1; ld_op = OP_NQ;   end
				OP_NQ:   begin load_go = 1'b1; ld_op = OP_SS;   end
				OP_SS:   begin load_go = 1'b1; ld_op = OP_RN;   end
				OP_RN:   begin load_go = 1'b1; ld_op = OP_RV1;  end
				OP_RV1:  begin load_go = 1'b1; ld_op = OP_RV2;  end
				OP_RV2: begin
					if (!outlier) begin
						load_go = 1'b1;
						ld_op   = OP_SQ;
					end else if (report && x_q > largest_q) begin
						load_go = 1'b1;
						ld_op   = OP_DIV;
					end
				end
				default: begin
					load_go = 1'b0;
				end
			endcase
		end
	end

	// operands for the operation being loaded
	always_comb begin
		a_in   = '0;
		b_in   = '0;
		ld_cnt = '0;
		unique case (ld_op)
			OP_SQ: begin
				a_in   = ACC_W'(x_cur);
				b_in   = B_W'(x_cur);
				ld_cnt = CNT_W'(DIG_SQ - 1);
			end
			OP_NX: begin
				a_in   = ACC_W'(x_cur);
				b_in   = B_W'(count_q);
				ld_cnt = CNT_W'(DIG_CNT - 1);
			end
			OP_D2: begin
				a_in   = ACC_W'(d_w);
				b_in   = B_W'(d_w);
				ld_cnt = CNT_W'(DIG_SUM - 1);
			end
			OP_LEFT: begin
				a_in   = acc;
				b_in   = B_W'({n_m1, {LEFT_SHIFT{1'b0}}});
				ld_cnt = CNT_W'(DIG_LEFT - 1);
			end
			OP_NQ: begin
				a_in   = ACC_W'(sq_q);
				b_in   = B_W'(count_q);
				ld_cnt = CNT_W'(DIG_CNT - 1);
			end
			OP_SS: begin
				a_in   = ACC_W'(sum_q);
				b_in   = B_W'(sum_q);
				ld_cnt = CNT_W'(DIG_SUM - 1);
			end
			OP_RN: begin
				a_in   = ACC_W'(var_w);
				b_in   = B_W'(count_q);
				ld_cnt = CNT_W'(DIG_CNT - 1);
			end
			OP_RV1, OP_RV2: begin
				a_in   = acc;
				b_in   = B_W'(thr_q);
				ld_cnt = CNT_W'(DIG_THR - 1);
			end
			OP_DIV: begin
				a_in   = ACC_W'({x_q, 1'b0}) + ACC_W'(prev_q);
				b_in   = B_W'(DIV_RECIP);
				ld_cnt = CNT_W'(DIG_DIV - 1);
			end
			default: begin
				a_in = '0;
			end
		endcase
	end

	// S*S is taken off the n*Q already in the accumulator
	assign mac_ctl.load = load_go;
	assign mac_ctl.clr  = load_go && (ld_op != OP_SS);
	assign mac_ctl.step = st_run;
	assign mac_ctl.sub  = st_run && (op_q == OP_SS);

	zpd_mac #(
		.ACC_W (ACC_W),
		.B_W   (B_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a_in   (a_in),
		.b_in   (b_in),
		.acc    (acc)
	);

	// item payload and intermediate holds
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= command;
			x_q   <= sample;
		end
		if (st_next && op_q == OP_LEFT) begin
			keep_q <= acc[LEFT_W-1:0];
		end
		if (st_out && out_free) begin
			status_q <= pend_q;
			level_q  <= smoothed_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_NX;
			cnt_q       <= '0;
			pend_q      <= STATUS_CALIB;
			out_valid_q <= 1'b0;
			calib_q     <= CALIB_RST;
			thr_q       <= THR_RST;
			hold_q      <= HOLD_RST;
			count_q     <= '0;
			sum_q       <= '0;
			sq_q        <= '0;
			prev_q      <= '0;
			largest_q   <= '0;
			smoothed_q  <= '0;
			ticks_q     <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_CALIB:   calib_q <= cfg_data[CALIB_BITS-1:0];
					CFG_THRESH:  thr_q   <= cfg_data[THR_BITS-1:0];
					CFG_HOLDOFF: hold_q  <= cfg_data[HOLD_BITS-1:0];
					default:     calib_q <= calib_q;
				endcase
			end

			if (st_out && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (command) begin
							pend_q  <= STATUS_TICK;
							state_q <= ST_OUT;
						end else begin
							pend_q  <= calibrating ? STATUS_CALIB : STATUS_BG;
							op_q    <= ld_op;
							cnt_q   <= ld_cnt;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (cnt_q == '0) begin
						state_q <= ST_NEXT;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_NEXT: begin
					if (op_q == OP_SQ && count_q != '1) begin
						count_q <= count_q + CB'(1);
						sum_q   <= sum_q + SUM_W'(x_q);
						sq_q    <= sq_q + SQ_W'(acc[2*SB-1:0]);
					end
					if (op_q == OP_RV2 && outlier) begin
						if (report) begin
							pend_q  <= STATUS_PEAK;
							ticks_q <= '0;
							if (x_q > largest_q) begin
								largest_q <= x_q;
							end
						end else begin
							pend_q <= STATUS_BG;
						end
					end
					if (op_q == OP_DIV) begin
						smoothed_q <= acc[DIV_SH +: SB];
					end
					if (load_go) begin
						op_q    <= ld_op;
						cnt_q   <= ld_cnt;
						state_q <= ST_RUN;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						if (cmd_q) begin
							if (ticks_q != '1) begin
								ticks_q <= ticks_q + TICK_BITS'(1);
							end
						end else begin
							prev_q <= x_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ZPD_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready)
	`ZPD_ASSERT(a_run_ends_in_next, st_run && cnt_q == '0 |=> st_next)
	`ZPD_ASSERT(a_peak_restarts_ticks, out_valid_q && status_q == STATUS_PEAK |-> ticks_q == '0)

endmodule

// ----- rtl/core/zpd_mac.sv -----
// Shared digit-serial multiply-accumulate unit for the z-score detector.
// Depends on zpd_pkg (digit width, control struct) and assert_macros.svh.
`include "assert_macros.svh"

module zpd_mac import zpd_pkg::*; #(
	parameter int ACC_W = 2 * SAMPLE_BITS_DEF + 3 * COUNT_BITS_DEF + 2 * THR_BITS,
	parameter int B_W   = SAMPLE_BITS_DEF + COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  zpd_mac_ctl_t     ctl,
	input  logic [ACC_W-1:0] a_in,
	input  logic [B_W-1:0]   b_in,
	output logic [ACC_W-1:0] acc
);

	logic [ACC_W-1:0]       a_q;
	logic [B_W-1:0]         b_q;
	logic [ACC_W-1:0]       acc_q;
	logic [ACC_W-1:0]       part;

	assign part = a_q * ACC_W'(b_q[DIG_W-1:0]);
	assign acc  = acc_q;

	// A moves up one digit per step so the partial product lands in place
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= a_in;
			b_q <= b_in;
		end else if (ctl.step) begin
			a_q <= a_q << DIG_W;
			b_q <= b_q >> DIG_W;
		end
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.step) begin
			acc_q <= ctl.sub ? acc_q - part : acc_q + part;
		end
	end

	`ZPD_NEVER(a_load_with_step, ctl.load && ctl.step)
	`ZPD_ASSERT(a_clr_needs_load, ctl.clr |-> ctl.load)
	`ZPD_ASSERT(a_sub_needs_step, ctl.sub |-> ctl.step)

endmodule
